### sv/stable_priority_queue_top_assert.svh
// assertion macros for the stable priority queue top level
// expects clk and rst_n in the including scope
`ifndef STABLE_PRIORITY_QUEUE_TOP_ASSERT_SVH
`define STABLE_PRIORITY_QUEUE_TOP_ASSERT_SVH

// same-cycle implication, checked outside reset
`define SPQ_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("spq check failed");

// next-cycle implication, checked outside reset
`define SPQ_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("spq check failed");

`endif

### sv/spq_pkg.sv
// shared types, constants and helpers for the stable priority queue
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package spq_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int FILL_W   = 5;
  localparam int TXH_W    = 48;
  localparam int TXL_W    = 64;
  localparam int RANK_W   = 8;

  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [FILL_W-1:0] fill_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_REMOVE = 1'b1
  } op_t;

  typedef struct packed {
    logic [TXH_W-1:0]  text_high;
    logic [TXL_W-1:0]  text_low;
    logic [RANK_W-1:0] rank;
  } entry_t;

  // ring position of logical slot k counted from the head
  function automatic idx_t ring_idx(idx_t hd, idx_t k);
    logic [IDX_W:0] sum;
    sum = {1'b0, hd} + {1'b0, k};
    if (sum >= (IDX_W+1)'(CAPACITY)) begin
      sum = sum - (IDX_W+1)'(CAPACITY);
    end
    return sum[IDX_W-1:0];
  endfunction

endpackage

`default_nettype wire

### sv/spq_if.sv
// valid/ready channel interfaces for the queue command and result streams
// depends on spq_pkg
`timescale 1ns / 1ps
`default_nettype none

interface spq_in_if import spq_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                operation;
  logic [TXH_W-1:0]    text_high;
  logic [TXL_W-1:0]    text_low;
  logic [RANK_W-1:0]   rank;

  modport source (output valid, operation, text_high, text_low, rank, input ready);
  modport sink   (input valid, operation, text_high, text_low, rank, output ready);
endinterface

interface spq_out_if import spq_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [1:0]          status;
  logic [TXH_W-1:0]    head_text_high;
  logic [TXL_W-1:0]    head_text_low;
  logic [RANK_W-1:0]   head_rank;
  logic [FILL_W-1:0]   fill;

  modport source (output valid, status, head_text_high, head_text_low, head_rank, fill,
                  input ready);
  modport sink   (input valid, status, head_text_high, head_text_low, head_rank, fill,
                  output ready);
endinterface

`default_nettype wire

### sv/spq_ram.sv
// entry store: one write port, one read port with registered read data
// depends on spq_pkg
`timescale 1ns / 1ps
`default_nettype none

module spq_ram import spq_pkg::*; (
  input  wire logic   clk,
  input  wire logic   we,
  input  wire idx_t   waddr,
  input  wire entry_t wdata,
  input  wire logic   re,
  input  wire idx_t   raddr,
  output entry_t      rdata
);

  entry_t mem [CAPACITY];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### sv/stable_priority_queue_top.sv
// stable sorted priority queue: ring buffer of entries plus insertion walk sequencer
// depends on spq_pkg, spq_if, spq_ram and stable_priority_queue_top_assert.svh
//
//  channel | dir | handshake          | payload
//  in_if   | in  | valid/ready        | operation, text_high, text_low, rank
//  out_if  | out | valid/ready        | status, head_text_high, head_text_low, head_rank, fill
//
// insert: walks back from the tail over the held entries whose rank exceeds the new rank;
//   when every held entry moves back, the new one lands at the head;
//   each of them is read and moved one slot back through the single ram read port
// remove: the head is read through the registered ram read port; rejects go straight to done
// one item at a time; in_if.ready is high only while the sequencer is idle
// a finished result waits in the output register; completion stalls only if
// the previous result has not been taken yet
// reset (rst_n low, synchronous) empties the queue; ram contents are not cleared
`timescale 1ns / 1ps
`default_nettype none

module stable_priority_queue_top import spq_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  spq_in_if.sink     in_if,
  spq_out_if.source  out_if
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_RD   = 5'b00010,
    S_CMP  = 5'b00100,
    S_HEAD = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  state_t  st_r, st_nxt;
  cnt_t    cnt_r, cnt_nxt;
  idx_t    hd_r, hd_nxt;
  idx_t    k_r, k_nxt;
  entry_t  new_r, new_nxt;
  status_t pend_status_r, pend_status_nxt;
  entry_t  pend_entry_r, pend_entry_nxt;

  logic    out_valid_r, out_valid_nxt;
  status_t out_status_r, out_status_nxt;
  entry_t  out_entry_r, out_entry_nxt;
  fill_t   out_fill_r, out_fill_nxt;

  logic    in_xfer;
  logic    out_free;
  logic    ram_we, ram_re;
  idx_t    ram_waddr, ram_raddr;
  entry_t  ram_wdata, ram_rdata;
  entry_t  in_entry;
  logic    moves_back;

  assign in_if.ready = (st_r == S_IDLE);
  assign in_xfer     = in_if.valid && in_if.ready;
  assign out_free    = !out_valid_r || out_if.ready;
  assign in_entry    = '{text_high: in_if.text_high, text_low: in_if.text_low,
                         rank: in_if.rank};
  // held entry read back goes behind the new one only if its rank is strictly greater
  assign moves_back  = ram_rdata.rank > new_r.rank;

  spq_ram u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // ram port control
  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = hd_r;
    ram_we    = 1'b0;
    ram_waddr = ring_idx(hd_r, k_r);
    ram_wdata = new_r;
    unique case (st_r)
      S_IDLE: begin
        ram_re = in_xfer && (op_t'(in_if.operation) == OP_REMOVE) && (cnt_r != '0);
      end
      S_RD: begin
        ram_raddr = ring_idx(hd_r, k_r - 1'b1);
        ram_re    = (k_r != '0);
        ram_we    = (k_r == '0);
      end
      S_CMP: begin
        ram_we    = 1'b1;
        ram_wdata = moves_back ? ram_rdata : new_r;
      end
      S_HEAD, S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  // sequencer
  always_comb begin
    st_nxt          = st_r;
    cnt_nxt         = cnt_r;
    hd_nxt          = hd_r;
    k_nxt           = k_r;
    new_nxt         = new_r;
    pend_status_nxt = pend_status_r;
    pend_entry_nxt  = pend_entry_r;
    out_valid_nxt   = out_valid_r && !out_if.ready;
    out_status_nxt  = out_status_r;
    out_entry_nxt   = out_entry_r;
    out_fill_nxt    = out_fill_r;
    unique case (st_r)
      S_IDLE: begin
        if (in_xfer) begin
          pend_entry_nxt = '0;
          pend_status_nxt = ST_OK;
          if (op_t'(in_if.operation) == OP_REMOVE) begin
            if (cnt_r == '0) begin
              pend_status_nxt = ST_EMPTY;
              st_nxt          = S_DONE;
            end else begin
              st_nxt = S_HEAD;
            end
          end else if (cnt_r == CNT_W'(CAPACITY)) begin
            pend_status_nxt = ST_FULL;
            st_nxt          = S_DONE;
          end else begin
            new_nxt = in_entry;
            k_nxt   = cnt_r[IDX_W-1:0];
            st_nxt  = S_RD;
          end
        end
      end
      S_RD: begin
        // at the head: the new entry lands in slot 0
        if (k_r == '0) begin
          cnt_nxt = cnt_r + 1'b1;
          st_nxt  = S_DONE;
        end else begin
          st_nxt = S_CMP;
        end
      end
      S_CMP: begin
        if (moves_back) begin
          k_nxt  = k_r - 1'b1;
          st_nxt = S_RD;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
          st_nxt  = S_DONE;
        end
      end
      S_HEAD: begin
        pend_entry_nxt = ram_rdata;
        hd_nxt         = ring_idx(hd_r, IDX_W'(1));
        cnt_nxt        = cnt_r - 1'b1;
        st_nxt         = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = pend_status_r;
          out_entry_nxt  = pend_entry_r;
          out_fill_nxt   = FILL_W'(cnt_r);
          st_nxt         = S_IDLE;
        end
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      cnt_r       <= '0;
      hd_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      cnt_r       <= cnt_nxt;
      hd_r        <= hd_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload and working registers
  always_ff @(posedge clk) begin
    k_r           <= k_nxt;
    new_r         <= new_nxt;
    pend_status_r <= pend_status_nxt;
    pend_entry_r  <= pend_entry_nxt;
    out_status_r  <= out_status_nxt;
    out_entry_r   <= out_entry_nxt;
    out_fill_r    <= out_fill_nxt;
  end

  // result channel
  assign out_if.valid          = out_valid_r;
  assign out_if.status         = out_status_r;
  assign out_if.head_text_high = out_entry_r.text_high;
  assign out_if.head_text_low  = out_entry_r.text_low;
  assign out_if.head_rank      = out_entry_r.rank;
  assign out_if.fill           = out_fill_r;

  // checks
`include "stable_priority_queue_top_assert.svh"

  `SPQ_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_r <= CNT_W'(CAPACITY))
  `SPQ_ASSERT_NXT(a_rm_head, in_xfer && in_if.operation && (cnt_r != '0), st_r == S_HEAD)
  `SPQ_ASSERT_IMP(a_cmp_not_head, st_r == S_CMP, k_r != '0)
  `SPQ_ASSERT_NXT(a_done_out, (st_r == S_DONE) && out_free, out_valid_r && (st_r == S_IDLE))

endmodule

`default_nettype wire

### verif/stable_priority_queue_top_tb.sv
// self-checking testbench for the stable priority queue top level
// depends on spq_pkg, spq_if and stable_priority_queue_top (with its ram)
`timescale 1ns / 1ps

module stable_priority_queue_top_tb;
  import spq_pkg::*;

  localparam int RANDOM_CMDS = 1200;
  localparam int TAIL_CMDS   = 150;
  localparam int PHASE_LEN   = 40;
  localparam int HOLD_START  = 2000;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_WAIT  = 60;

  typedef struct {
    status_t status;
    entry_t  head;
    fill_t   fill;
  } outcome_t;

  // shadow of the sorted queue plus the outcomes still owed by the block
  class queue_tracker;
    entry_t   held[$];
    outcome_t awaited[$];
    int mismatches;
    int inserts;
    int removes;
    int full_refusals;
    int empty_refusals;
    int checked;

    task report(string msg);
      mismatches++;
      $display("mismatch: %s", msg);
    endtask

    // work out the outcome of one accepted command
    function void note_command(op_t op, entry_t item);
      outcome_t o;
      int pos;
      o.status = ST_OK;
      o.head   = '0;
      if (op == OP_INSERT) begin
        inserts++;
        if (held.size() >= CAPACITY) begin
          o.status = ST_FULL;
          full_refusals++;
        end else begin
          // goes behind every entry of equal or smaller rank
          pos = 0;
          while (pos < held.size() && held[pos].rank <= item.rank) pos++;
          held.insert(pos, item);
        end
      end else begin
        removes++;
        if (held.size() == 0) begin
          o.status = ST_EMPTY;
          empty_refusals++;
        end else begin
          o.head = held.pop_front();
        end
      end
      o.fill = fill_t'(held.size());
      awaited.push_back(o);
    endfunction

    // compare one result transfer with the oldest outcome owed
    task check_outcome(logic [1:0] status, logic [TXH_W-1:0] th, logic [TXL_W-1:0] tl,
                       logic [RANK_W-1:0] rk, logic [FILL_W-1:0] fill);
      outcome_t o;
      if (awaited.size() == 0) begin
        report("result transfer with no command outstanding");
      end else begin
        o = awaited.pop_front();
        checked++;
        if (status !== o.status)
          report($sformatf("result %0d status %0d, want %0d", checked, status, o.status));
        if (th !== o.head.text_high)
          report($sformatf("result %0d text_high %h, want %h", checked, th,
                           o.head.text_high));
        if (tl !== o.head.text_low)
          report($sformatf("result %0d text_low %h, want %h", checked, tl,
                           o.head.text_low));
        if (rk !== o.head.rank)
          report($sformatf("result %0d rank %0d, want %0d", checked, rk, o.head.rank));
        if (fill !== o.fill)
          report($sformatf("result %0d fill %0d, want %0d", checked, fill, o.fill));
      end
    endtask
  endclass

  logic clk;
  logic rst_n;
  bit   tail_calm;
  int   cmd_idx;
  queue_tracker sb = new();

  spq_in_if  in_if ();
  spq_out_if out_if ();

  stable_priority_queue_top uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if)
  );

  // 4 ns clock
  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // offer one command, with an optional idle burst first, and wait for its transfer
  task automatic send_cmd(op_t op, logic [TXH_W-1:0] th, logic [TXL_W-1:0] tl,
                          logic [RANK_W-1:0] rk);
    entry_t item;
    bit quiet;
    quiet = tail_calm || ((cmd_idx / 64) % 3 == 2);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_if.valid     <= 1'b1;
    in_if.operation <= op;
    in_if.text_high <= th;
    in_if.text_low  <= tl;
    in_if.rank      <= rk;
    do @(posedge clk); while (!in_if.ready);
    item.text_high = th;
    item.text_low  = tl;
    item.rank      = rk;
    sb.note_command(op, item);
    cmd_idx++;
  endtask

  // result side: random stalls, quiet windows and one long hold-off
  initial begin : result_sink
    int cycles;
    int n;
    bit held_off;
    cycles   = 0;
    held_off = 0;
    out_if.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (!held_off && cycles >= HOLD_START) begin
        held_off = 1;
        out_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        cycles += HOLD_CYCLES;
      end else if (!tail_calm && ((cycles / 200) % 3 != 1) && $urandom_range(0, 4) == 0) begin
        n = $urandom_range(1, 10);
        out_if.ready <= 1'b0;
        repeat (n) @(posedge clk);
        cycles += n;
      end else begin
        out_if.ready <= 1'b1;
        @(posedge clk);
        cycles++;
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      sb.check_outcome(out_if.status, out_if.head_text_high, out_if.head_text_low,
                       out_if.head_rank, out_if.fill);
    end
  end

  // stimulus and end of run
  initial begin : command_source
    logic [RANK_W-1:0] dir_ranks [16];
    int ins_pct;
    int rank_mode;
    logic [RANK_W-1:0] rk;
    op_t op;
    dir_ranks = '{8'd8, 8'd8, 8'd0, 8'd255, 8'd8, 8'd3, 8'd255, 8'd0,
                  8'd1, 8'd200, 8'd8, 8'd127, 8'd128, 8'd0, 8'd254, 8'd9};
    tail_calm = 0;
    cmd_idx   = 0;
    ins_pct   = 50;
    rank_mode = 0;
    rst_n           <= 1'b0;
    in_if.valid     <= 1'b0;
    in_if.operation <= OP_INSERT;
    in_if.text_high <= '0;
    in_if.text_low  <= '0;
    in_if.rank      <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: remove on empty, fill with ties and extreme ranks, insert when full, then removes and a tied insert
    send_cmd(OP_REMOVE, {TXH_W{1'b1}}, {TXL_W{1'b1}}, 8'hff);
    send_cmd(OP_INSERT, {TXH_W{1'b1}}, {TXL_W{1'b1}}, dir_ranks[0]);
    send_cmd(OP_INSERT, '0, '0, dir_ranks[1]);
    send_cmd(OP_INSERT, 48'haaaa_aaaa_aaaa, 64'h5555_5555_5555_5555, dir_ranks[2]);
    send_cmd(OP_INSERT, 48'h5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa, dir_ranks[3]);
    for (int i = 4; i < 16; i++) begin
      send_cmd(OP_INSERT, TXH_W'({$urandom, $urandom}), {$urandom, $urandom},
               dir_ranks[i]);
    end
    send_cmd(OP_INSERT, {TXH_W{1'b1}}, {TXL_W{1'b1}}, 8'd0);
    repeat (5) send_cmd(OP_REMOVE, TXH_W'({$urandom, $urandom}), {$urandom, $urandom},
                        RANK_W'($urandom));
    send_cmd(OP_INSERT, TXH_W'({$urandom, $urandom}), {$urandom, $urandom}, 8'd8);
    send_cmd(OP_REMOVE, '0, '0, '0);

    // random: phases that lean to inserts or removes, with narrow or wide ranks
    for (int i = 0; i < RANDOM_CMDS; i++) begin
      if (i % PHASE_LEN == 0) begin
        case ($urandom_range(0, 2))
          0: ins_pct = 85;
          1: ins_pct = 15;
          default: ins_pct = 50;
        endcase
        rank_mode = $urandom_range(0, 2);
      end
      if (i == RANDOM_CMDS - TAIL_CMDS) tail_calm = 1;
      case (rank_mode)
        0: rk = RANK_W'($urandom);
        1: rk = RANK_W'($urandom_range(0, 3));
        default: rk = $urandom_range(0, 1) ? 8'd255 : 8'd0;
      endcase
      op = ($urandom_range(0, 99) < ins_pct) ? OP_INSERT : OP_REMOVE;
      send_cmd(op, TXH_W'({$urandom, $urandom}), {$urandom, $urandom}, rk);
    end
    in_if.valid <= 1'b0;

    // let the last results drain
    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    $display("covered %0d commands: %0d inserts (%0d refused as full), %0d removes (%0d on empty)",
             cmd_idx, sb.inserts, sb.full_refusals, sb.removes, sb.empty_refusals);
    $display("result side held off for %0d cycles once while commands kept coming",
             HOLD_CYCLES);
    if (sb.mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // hang guard
  initial begin : watchdog
    #2000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

### files.f
+incdir+sv
sv/spq_pkg.sv
sv/spq_if.sv
sv/spq_ram.sv
sv/stable_priority_queue_top.sv
verif/stable_priority_queue_top_tb.sv
